/* design/arat_pkg.sv */
// ----------------------------------------------------------------------------
// arat_pkg
// Shared types, register map and reset values for the affine rectangle
// transform core.
// ----------------------------------------------------------------------------
package arat_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ITEM_W  = 4 * COORD_W;

  // Register index, byte address = 4 * index
  typedef enum logic [IDX_W-1:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_SHIFT    = 3'd6
  } reg_idx_t;

  localparam logic [COORD_W-1:0] RST_COEF_A   = 32'd1;
  localparam logic [COORD_W-1:0] RST_COEF_B   = 32'd0;
  localparam logic [COORD_W-1:0] RST_COEF_C   = 32'd0;
  localparam logic [COORD_W-1:0] RST_COEF_D   = 32'd1;
  localparam logic [COORD_W-1:0] RST_OFFSET_X = 32'd0;
  localparam logic [COORD_W-1:0] RST_OFFSET_Y = 32'd0;
  localparam logic [SHIFT_W-1:0] RST_SHIFT    = 5'd0;

  typedef struct packed {
    logic [COORD_W-1:0] coef_a;
    logic [COORD_W-1:0] coef_b;
    logic [COORD_W-1:0] coef_c;
    logic [COORD_W-1:0] coef_d;
    logic [COORD_W-1:0] offset_x;
    logic [COORD_W-1:0] offset_y;
    logic [SHIFT_W-1:0] shift_amount;
  } cfg_t;

  // Per-stage load enables for the corner mapping pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

/* design/arat_cfg.sv */
// ----------------------------------------------------------------------------
// arat_cfg
// APB register file holding the transform coefficients, offsets and shift.
// ----------------------------------------------------------------------------
module arat_cfg
  import arat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_COEF_A:   cfg_nxt.coef_a       = pwdata;
        REG_COEF_B:   cfg_nxt.coef_b       = pwdata;
        REG_COEF_C:   cfg_nxt.coef_c       = pwdata;
        REG_COEF_D:   cfg_nxt.coef_d       = pwdata;
        REG_OFFSET_X: cfg_nxt.offset_x     = pwdata;
        REG_OFFSET_Y: cfg_nxt.offset_y     = pwdata;
        REG_SHIFT:    cfg_nxt.shift_amount = pwdata[SHIFT_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COEF_A:   prdata = cfg_r.coef_a;
      REG_COEF_B:   prdata = cfg_r.coef_b;
      REG_COEF_C:   prdata = cfg_r.coef_c;
      REG_COEF_D:   prdata = cfg_r.coef_d;
      REG_OFFSET_X: prdata = cfg_r.offset_x;
      REG_OFFSET_Y: prdata = cfg_r.offset_y;
      REG_SHIFT:    prdata = {{(APB_DW-SHIFT_W){1'b0}}, cfg_r.shift_amount};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_a       <= RST_COEF_A;
      cfg_r.coef_b       <= RST_COEF_B;
      cfg_r.coef_c       <= RST_COEF_C;
      cfg_r.coef_d       <= RST_COEF_D;
      cfg_r.offset_x     <= RST_OFFSET_X;
      cfg_r.offset_y     <= RST_OFFSET_Y;
      cfg_r.shift_amount <= RST_SHIFT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/arat_map.sv */
// ----------------------------------------------------------------------------
// arat_map
// Three-stage mapping of one corner: products, sums, arithmetic shift.
// ----------------------------------------------------------------------------
module arat_map
  import arat_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          en,
  input  cfg_t               cfg,
  input  logic [COORD_W-1:0] x,
  input  logic [COORD_W-1:0] y,
  output logic [COORD_W-1:0] px,
  output logic [COORD_W-1:0] py
);

  // stage 1: products, low word only (wraps)
  logic [COORD_W-1:0] ax_r, cy_r, bx_r, dy_r;
  // stage 2: sums with offset
  logic [COORD_W-1:0] sx_r, sy_r;
  // stage 3: shifted
  logic [COORD_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ax_r <= COORD_W'(cfg.coef_a * x);
      cy_r <= COORD_W'(cfg.coef_c * y);
      bx_r <= COORD_W'(cfg.coef_b * x);
      dy_r <= COORD_W'(cfg.coef_d * y);
    end
    if (en.s2) begin
      sx_r <= ax_r + cy_r + cfg.offset_x;
      sy_r <= bx_r + dy_r + cfg.offset_y;
    end
    if (en.s3) begin
      px_r <= COORD_W'($signed(sx_r) >>> cfg.shift_amount);
      py_r <= COORD_W'($signed(sy_r) >>> cfg.shift_amount);
    end
  end

  assign px = px_r;
  assign py = py_r;

endmodule

/* design/arat_sort.sv */
// ----------------------------------------------------------------------------
// arat_sort
// Per-axis signed min/max of the two mapped corners into the output register.
// ----------------------------------------------------------------------------
module arat_sort
  import arat_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [COORD_W-1:0] p1x,
  input  logic [COORD_W-1:0] p1y,
  input  logic [COORD_W-1:0] p2x,
  input  logic [COORD_W-1:0] p2y,
  output logic [ITEM_W-1:0]  box
);

  logic               xs, ys;
  logic [ITEM_W-1:0]  box_r;

  assign xs = $signed(p2x) < $signed(p1x);
  assign ys = $signed(p2y) < $signed(p1y);

  always_ff @(posedge clk) begin
    if (en) begin
      box_r <= {ys ? p1y : p2y,
                xs ? p1x : p2x,
                ys ? p2y : p1y,
                xs ? p2x : p1x};
    end
  end

  assign box = box_r;

endmodule

/* design/affine_rectangle_transform_core.sv */
// ----------------------------------------------------------------------------
// affine_rectangle_transform_core
// Maps both corners of a rectangle through a 2x3 integer affine transform and
// sorts them into a low and a high corner.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*  stream: one rectangle request per handshake (in_tvalid & in_tready),
//    tdata = {second_y, second_x, first_y, first_x}, first_x in bits [31:0].
//  - out_* stream: one box per request, tdata = {high_y, high_x, low_y, low_x}.
//  - cfg_* APB port: registers at 4*i, i = coef_a, coef_b, coef_c, coef_d,
//    offset_x, offset_y, shift_amount. Write only while the core is idle.
//  - Pipeline: four register stages (multiply, add, shift, sort/output
//    register); out_tvalid rises once a request has reached the fourth stage.
//  - Throughput: one request per cycle; each stage is a register with its own
//    valid bit, so a request can enter every cycle while the output drains.
//  - Stall: when out_tready is low, bubbles in the pipe still close up, so
//    input is taken until all four stages are full; nothing is dropped.
//  - Reset (rst_n low, synchronous): pipe empties, registers return to the
//    identity transform with zero offset and zero shift.
// ----------------------------------------------------------------------------
module affine_rectangle_transform_core
  import arat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // rectangle requests
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ITEM_W-1:0] in_tdata,   // first_x, first_y, second_x, second_y
  // boxes
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ITEM_W-1:0] out_tdata,  // low_x, low_y, high_x, high_y
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t               cfg;
  stage_en_t          en;
  logic               ld4;
  logic               v1_r, v2_r, v3_r, v4_r;
  logic               v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic [COORD_W-1:0] p1x, p1y, p2x, p2y;

  arat_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // A stage loads when it is empty or its content moves on this cycle.
  always_comb begin
    ld4       = !v4_r || out_tready;
    en.s3     = !v3_r || ld4;
    en.s2     = !v2_r || en.s3;
    en.s1     = !v1_r || en.s2;
    in_tready = en.s1;

    v1_nxt = en.s1 ? in_tvalid : v1_r;
    v2_nxt = en.s2 ? v1_r      : v2_r;
    v3_nxt = en.s3 ? v2_r      : v3_r;
    v4_nxt = ld4   ? v3_r      : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  arat_map u_map_first (
    .clk (clk),
    .en  (en),
    .cfg (cfg),
    .x   (in_tdata[COORD_W-1:0]),
    .y   (in_tdata[2*COORD_W-1:COORD_W]),
    .px  (p1x),
    .py  (p1y)
  );

  arat_map u_map_second (
    .clk (clk),
    .en  (en),
    .cfg (cfg),
    .x   (in_tdata[3*COORD_W-1:2*COORD_W]),
    .y   (in_tdata[4*COORD_W-1:3*COORD_W]),
    .px  (p2x),
    .py  (p2y)
  );

  arat_sort u_sort (
    .clk (clk),
    .en  (ld4),
    .p1x (p1x),
    .p1y (p1y),
    .p2x (p2x),
    .p2y (p2y),
    .box (out_tdata)
  );

  assign out_tvalid = v4_r;

endmodule

/* design/arat_checker.sv */
// ----------------------------------------------------------------------------
// arat_checker
// Port-level checks on the result stream of the transform core.
// ----------------------------------------------------------------------------
module arat_checker
  import arat_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [ITEM_W-1:0] out_tdata
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // and unchanged
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  // low corner never above high corner
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[COORD_W-1:0]) <= $signed(out_tdata[3*COORD_W-1:2*COORD_W])) &&
      ($signed(out_tdata[2*COORD_W-1:COORD_W]) <= $signed(out_tdata[4*COORD_W-1:3*COORD_W])))
    else $error("box corners not sorted");

endmodule

bind affine_rectangle_transform_core arat_checker u_arat_checker (.*);
